// File: design/cll_pkg.sv
// Shared types, character codes and status codes for the configuration line lexer.
// Used by cll_front, cll_emit and config_line_lexer; depends on nothing.
`default_nettype none
package cll_pkg;

	localparam int LINE_BYTES_DEF    = 128;
	localparam int LOGICAL_BYTES_DEF = 512;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_HASH  = 8'd35;
	localparam logic [7:0] CH_BSL   = 8'd92;

	localparam logic [1:0] ST_CHUNK = 2'd0;
	localparam logic [1:0] ST_PHYS  = 2'd1;
	localparam logic [1:0] ST_LOGI  = 2'd2;

	// One event from the byte front end to the output sequencer.
	typedef struct packed {
		logic        err;
		logic        deliver;
		logic [1:0]  status;
		logic [15:0] line;
	} evt_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR);
	endfunction

	function automatic logic is_blank_nl(input logic [7:0] b);
		return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_NL);
	endfunction

endpackage
`default_nettype wire

// File: design/cll_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module cll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire                      clk,
	input  wire                      wr_en,
	input  wire [$clog2(DEPTH)-1:0]  wr_addr,
	input  wire [WIDTH-1:0]          wr_data,
	input  wire                      rd_en,
	input  wire [$clog2(DEPTH)-1:0]  rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: design/cll_front.sv
// Byte front end: comment cut, trim and continuation per physical line; writes
// kept bytes straight into the logical line buffer. Uses cll_pkg.
`default_nettype none
module cll_front #(
	parameter int LINE_BYTES    = cll_pkg::LINE_BYTES_DEF,
	parameter int LOGICAL_BYTES = cll_pkg::LOGICAL_BYTES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              acc,
	input  wire [7:0]                        text_byte,
	input  wire                              last_byte,
	output logic                             wr_en,
	output logic [$clog2(LOGICAL_BYTES)-1:0] wr_addr,
	output logic [7:0]                       wr_data,
	output cll_pkg::evt_t                    evt,
	output logic [$clog2(LOGICAL_BYTES)-1:0] dlen
);

	localparam int AW = $clog2(LOGICAL_BYTES);
	localparam int PW = $clog2(LINE_BYTES);
	localparam int SW = AW + 2;

	logic [AW-1:0] ll_q, n_ll;
	logic [15:0]   first_q, n_first, lc_q, n_lc;
	logic [PW-1:0] pc_q, n_pc, kept_q, n_kept, tlen_q, n_tlen, bs_q, n_bs;
	logic          quote_q, n_quote, comment_q, n_comment, disc_q, n_disc;

	logic [15:0]   cur;
	logic          content, keep, cont;
	logic [PW-1:0] llen;
	logic [SW-1:0] sum, wsum;
	logic [AW-1:0] nll;

	assign wsum    = SW'(ll_q) + SW'(kept_q);
	assign wr_addr = wsum[AW-1:0];
	assign wr_data = text_byte;
	// Bytes past the buffer end belong to a line that overflows anyway or are trailing bytes that the trim drops.
	assign wr_en   = keep && (wsum < SW'(LOGICAL_BYTES));

	always_comb begin
		cur       = (lc_q != 16'hFFFF) ? lc_q + 16'd1 : lc_q;
		content   = (text_byte != cll_pkg::CH_NL) && (text_byte != 8'd0);
		n_ll      = ll_q;
		n_first   = first_q;
		n_lc      = lc_q;
		n_pc      = pc_q;
		n_kept    = kept_q;
		n_tlen    = tlen_q;
		n_bs      = bs_q;
		n_quote   = quote_q;
		n_comment = comment_q;
		n_disc    = disc_q;
		keep      = 1'b0;
		cont      = 1'b0;
		llen      = '0;
		sum       = '0;
		nll       = '0;
		evt       = '0;
		dlen      = '0;
		if (acc && !disc_q) begin
			if (content && (pc_q == PW'(LINE_BYTES - 1))) begin
				evt.err    = 1'b1;
				evt.status = cll_pkg::ST_PHYS;
				evt.line   = cur;
				n_disc     = 1'b1;
			end else begin
				if (content) begin
					n_pc = pc_q + PW'(1);
					if (!comment_q) begin
						if (text_byte == cll_pkg::CH_HASH && !quote_q) begin
							n_comment = 1'b1;
						end else begin
							if (text_byte == cll_pkg::CH_QUOTE) begin
								n_quote = !quote_q;
							end
							keep   = 1'b1;
							n_kept = kept_q + PW'(1);
							if (!cll_pkg::is_blank(text_byte)) begin
								// The backslash run only grows across adjacent kept bytes.
								if (text_byte == cll_pkg::CH_BSL) begin
									n_bs = (tlen_q == kept_q) ? bs_q + PW'(1) : PW'(1);
								end else begin
									n_bs = '0;
								end
								n_tlen = kept_q + PW'(1);
							end
						end
					end
				end
				if (text_byte == cll_pkg::CH_NL || last_byte) begin
					llen      = n_tlen - PW'(n_bs != '0);
					cont      = n_bs[0] && !last_byte;
					n_pc      = '0;
					n_kept    = '0;
					n_tlen    = '0;
					n_bs      = '0;
					n_quote   = 1'b0;
					n_comment = 1'b0;
					n_lc      = cur;
					sum       = SW'(ll_q) + SW'(llen) + SW'(1);
					if (sum >= SW'(LOGICAL_BYTES)) begin
						evt.err    = 1'b1;
						evt.status = cll_pkg::ST_LOGI;
						evt.line   = (first_q != 16'd0) ? first_q : cur;
						n_disc     = 1'b1;
					end else begin
						if (llen != '0 && ll_q == '0 && first_q == 16'd0) begin
							n_first = cur;
						end
						nll  = ll_q + AW'(llen);
						n_ll = nll;
						if (!cont) begin
							evt.deliver = (nll != '0);
							evt.status  = cll_pkg::ST_CHUNK;
							evt.line    = n_first;
							dlen        = nll;
							n_ll        = '0;
							n_first     = 16'd0;
						end
					end
				end
			end
		end
		if (acc && last_byte) begin
			n_ll      = '0;
			n_first   = 16'd0;
			n_lc      = 16'd0;
			n_disc    = 1'b0;
			n_pc      = '0;
			n_kept    = '0;
			n_tlen    = '0;
			n_bs      = '0;
			n_quote   = 1'b0;
			n_comment = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ll_q      <= '0;
			first_q   <= '0;
			lc_q      <= '0;
			pc_q      <= '0;
			kept_q    <= '0;
			tlen_q    <= '0;
			bs_q      <= '0;
			quote_q   <= 1'b0;
			comment_q <= 1'b0;
			disc_q    <= 1'b0;
		end else begin
			ll_q      <= n_ll;
			first_q   <= n_first;
			lc_q      <= n_lc;
			pc_q      <= n_pc;
			kept_q    <= n_kept;
			tlen_q    <= n_tlen;
			bs_q      <= n_bs;
			quote_q   <= n_quote;
			comment_q <= n_comment;
			disc_q    <= n_disc;
		end
	end

endmodule
`default_nettype wire

// File: design/cll_emit.sv
// Output sequencer: rescans the logical line in the buffer for a comment and
// trailing blanks, then reads it out in 8-byte chunks. Uses cll_pkg.
`default_nettype none
module cll_emit #(
	parameter int LOGICAL_BYTES = cll_pkg::LOGICAL_BYTES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  cll_pkg::evt_t                    evt,
	input  wire [$clog2(LOGICAL_BYTES)-1:0]  dlen,
	output logic                             rd_en,
	output logic [$clog2(LOGICAL_BYTES)-1:0] rd_addr,
	input  wire [7:0]                        rd_data,
	output logic                             busy,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [87:0]                      m_tdata,  // chunk_data, chunk_bytes, line_number
	output logic [1:0]                       m_tuser,  // status
	output logic                             m_tlast   // last_chunk
);

	localparam int AW = $clog2(LOGICAL_BYTES);

	localparam logic [1:0] SQ_IDLE = 2'd0;
	localparam logic [1:0] SQ_SCAN = 2'd1;
	localparam logic [1:0] SQ_READ = 2'd2;
	localparam logic [1:0] SQ_SEND = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] len_q, addr_q, good_q, idx_s1;
	logic [15:0]   line_q;
	logic          rd_s1, inq_q, cut_q;
	logic [3:0]    iss_q, cnt_q;
	logic [63:0]   chunk_q;

	logic          mv_q, ml_q;
	logic [1:0]    ms_q;
	logic [63:0]   md_q;
	logic [3:0]    mb_q;
	logic [15:0]   mn_q;

	logic          p_inq, p_cut, out_free, load;
	logic [AW-1:0] p_good;

	always_comb begin
		p_inq  = inq_q;
		p_cut  = cut_q;
		p_good = good_q;
		if (!cut_q) begin
			if (rd_data == cll_pkg::CH_QUOTE) begin
				p_inq = !inq_q;
			end else if (rd_data == cll_pkg::CH_HASH && !inq_q) begin
				p_cut = 1'b1;
			end
			if (!p_cut && !cll_pkg::is_blank_nl(rd_data)) begin
				p_good = idx_s1 + AW'(1);
			end
		end
		unique case (state_q)
			SQ_SCAN: rd_en = (addr_q != len_q);
			SQ_READ: rd_en = (addr_q != len_q) && (iss_q != 4'd8);
			default: rd_en = 1'b0;
		endcase
	end

	assign rd_addr  = addr_q;
	assign out_free = !mv_q || m_tready;
	assign load     = evt.err || (state_q == SQ_SEND && out_free);
	assign busy     = (state_q != SQ_IDLE) || mv_q;

	assign m_tvalid = mv_q;
	assign m_tdata  = {4'd0, mn_q, mb_q, md_q};
	assign m_tuser  = ms_q;
	assign m_tlast  = ml_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			rd_s1   <= 1'b0;
			mv_q    <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			if (load) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
			unique case (state_q)
				SQ_IDLE: begin
					if (evt.deliver) begin
						state_q <= SQ_SCAN;
					end
				end
				SQ_SCAN: begin
					if (rd_s1 && idx_s1 == len_q - AW'(1)) begin
						state_q <= (p_good == '0) ? SQ_IDLE : SQ_READ;
					end
				end
				SQ_READ: begin
					if (rd_s1 && (idx_s1 + AW'(1) == len_q || idx_s1[2:0] == 3'b111)) begin
						state_q <= SQ_SEND;
					end
				end
				SQ_SEND: begin
					if (out_free) begin
						state_q <= (addr_q == len_q) ? SQ_IDLE : SQ_READ;
					end
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (rd_en) begin
			addr_q <= addr_q + AW'(1);
		end
		if (state_q == SQ_IDLE && evt.deliver) begin
			len_q   <= dlen;
			line_q  <= evt.line;
			addr_q  <= '0;
			inq_q   <= 1'b0;
			cut_q   <= 1'b0;
			good_q  <= '0;
		end
		if (state_q == SQ_SCAN && rd_s1) begin
			inq_q  <= p_inq;
			cut_q  <= p_cut;
			good_q <= p_good;
			if (idx_s1 == len_q - AW'(1)) begin
				// The scan result becomes the length to read out.
				len_q   <= p_good;
				addr_q  <= '0;
				iss_q   <= 4'd0;
				cnt_q   <= 4'd0;
				chunk_q <= '0;
			end
		end
		if (state_q == SQ_READ) begin
			if (rd_en) begin
				iss_q <= iss_q + 4'd1;
			end
			if (rd_s1) begin
				cnt_q <= cnt_q + 4'd1;
				for (int l = 0; l < 8; l++) begin
					if (idx_s1[2:0] == 3'(l)) begin
						chunk_q[l*8 +: 8] <= rd_data;
					end
				end
			end
		end
		if (state_q == SQ_SEND && out_free) begin
			iss_q   <= 4'd0;
			cnt_q   <= 4'd0;
			chunk_q <= '0;
		end
		if (evt.err) begin
			ms_q <= evt.status;
			md_q <= '0;
			mb_q <= 4'd0;
			mn_q <= evt.line;
			ml_q <= 1'b1;
		end else if (state_q == SQ_SEND && out_free) begin
			ms_q <= cll_pkg::ST_CHUNK;
			md_q <= chunk_q;
			mb_q <= cnt_q;
			mn_q <= line_q;
			ml_q <= (addr_q == len_q);
		end
	end

`ifndef SYNTHESIS
	a_evt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(evt.err && evt.deliver))
		else $error("error and delivery in the same cycle");
	a_evt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.err || evt.deliver) |-> (state_q == SQ_IDLE && !mv_q))
		else $error("event while the sequencer is busy");
	a_chunk_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(mv_q && ms_q == cll_pkg::ST_CHUNK) |-> (mb_q != 4'd0 && mb_q <= 4'd8))
		else $error("chunk with a bad byte count");
	a_read_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> (state_q == SQ_SCAN || state_q == SQ_READ))
		else $error("read data returned outside scan or readout");
`endif

endmodule
`default_nettype wire

// File: design/config_line_lexer.sv
// Configuration line lexer: INI-style lines with comments, quotes and continuation.
// Channels: slave side takes one text byte per beat (s_tdata[7:0], s_tlast marks
// the final byte of the text). Master side gives one result per beat: m_tuser is
// the status (chunk, physical line too long, logical line too long), m_tdata holds
// chunk_data [63:0], chunk_bytes [67:64], line_number [83:68]; m_tlast marks the
// final chunk of a logical line and every error beat.
// Throughput: one byte per cycle while a line is being gathered. A line end that
// delivers a logical line holds s_tready low while the buffer read port rescans
// its bytes, then while it is read out in chunks of up to 8 bytes; every result
// beat must be taken before the next byte enters.
// A stalled receiver holds the result register and s_tready stays low.
// Reset clears the front end and sequencer control; the buffer needs no clearing.
// After an error, bytes are accepted and dropped until s_tlast.
// Uses cll_pkg, cll_ram, cll_front and cll_emit.
`default_nettype none
module config_line_lexer #(
	parameter int LINE_BYTES    = cll_pkg::LINE_BYTES_DEF,
	parameter int LOGICAL_BYTES = cll_pkg::LOGICAL_BYTES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [7:0]   s_tdata,   // text_byte
	input  wire         s_tlast,   // last_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [87:0] m_tdata,   // chunk_data, chunk_bytes, line_number, zero pad
	output logic [1:0]  m_tuser,   // status
	output logic        m_tlast    // last_chunk
);

	localparam int AW = $clog2(LOGICAL_BYTES);

	logic          acc, busy, wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr, dlen;
	logic [7:0]    wr_data, rd_data;
	cll_pkg::evt_t evt;

	assign s_tready = !busy;
	assign acc      = s_tvalid && !busy;

	cll_front #(.LINE_BYTES(LINE_BYTES), .LOGICAL_BYTES(LOGICAL_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .acc(acc), .text_byte(s_tdata), .last_byte(s_tlast),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data), .evt(evt), .dlen(dlen)
	);

	cll_ram #(.WIDTH(8), .DEPTH(LOGICAL_BYTES)) u_buf (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	cll_emit #(.LOGICAL_BYTES(LOGICAL_BYTES)) u_emit (
		.clk(clk), .arst_n(arst_n), .evt(evt), .dlen(dlen),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data), .busy(busy),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

endmodule
`default_nettype wire
